// File: hw/rtl/hid_report_key_change_detect_core_assert.svh
// Assertion macros for the keyboard report key-change detector.
// Depends on signals named clock and reset in the including module.
`ifndef HID_REPORT_KEY_CHANGE_DETECT_CORE_ASSERT_SVH
`define HID_REPORT_KEY_CHANGE_DETECT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HRKCD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hrkcd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HRKCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hrkcd assertion failed");

`endif

// File: hw/rtl/hrkcd_pkg.sv
// Shared types and constants for the keyboard report key-change detector.
// No dependencies.
package hrkcd_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int KEY_W       = 8;
   localparam int EVENTS      = 2 * KEY_SLOTS;
   localparam int EVENT_IDX_W = $clog2(EVENTS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] keys_type;

   // One classified report waiting for the event sequencer.
   typedef struct packed {
      logic [KEY_W-1:0]     mods;
      logic [KEY_W-1:0]     prev_mods;
      keys_type             cur_keys;
      keys_type             prev_keys;
      logic [KEY_SLOTS-1:0] release_mask;
      logic [KEY_SLOTS-1:0] press_mask;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hw/rtl/hrkcd_if.sv
// Valid/ready channel interfaces for reports in and key events out.
// Depends on nothing.
interface hrkcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifiers;
   logic [7:0] key_1;
   logic [7:0] key_2;
   logic [7:0] key_3;
   logic [7:0] key_4;
   logic [7:0] key_5;
   logic [7:0] key_6;

   modport source(output valid, modifiers, key_1, key_2, key_3, key_4, key_5, key_6,
                  input ready);
   modport sink(input valid, modifiers, key_1, key_2, key_3, key_4, key_5, key_6,
                output ready);
endinterface

interface hrkcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic [7:0] event_modifiers;
   logic       pressed;
   logic       last;

   modport source(output valid, key_code, event_modifiers, pressed, last, input ready);
   modport sink(input valid, key_code, event_modifiers, pressed, last, output ready);
endinterface

// File: hw/rtl/hrkcd_front.sv
// Front end: accepts reports, marks new and vanished keys, keeps the previous report.
// Depends on hrkcd_pkg and hrkcd_req_if.
module hrkcd_front (
   input  logic                  clock,
   input  logic                  reset,
   hrkcd_req_if.sink             req_ch,
   input  hrkcd_pkg::qstat_type  qstat,
   output logic                  q_push,
   output hrkcd_pkg::entry_type  q_entry
);
   import hrkcd_pkg::*;

   logic [KEY_W-1:0]     prev_mods_ff;
   logic [KEY_W-1:0]     prev_mods_in;
   keys_type             prev_keys_ff;
   keys_type             prev_keys_in;
   keys_type             cur_keys;
   logic [KEY_SLOTS-1:0] press_mask;
   logic [KEY_SLOTS-1:0] release_mask;
   logic [KEY_SLOTS-1:0] cur_seen;
   logic [KEY_SLOTS-1:0] prev_seen;
   logic                 accept;

   assign cur_keys[0] = req_ch.key_1;
   assign cur_keys[1] = req_ch.key_2;
   assign cur_keys[2] = req_ch.key_3;
   assign cur_keys[3] = req_ch.key_4;
   assign cur_keys[4] = req_ch.key_5;
   assign cur_keys[5] = req_ch.key_6;

   assign req_ch.ready = !qstat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         cur_seen[i]  = 1'b0;
         prev_seen[i] = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (cur_keys[i] == prev_keys_ff[j]) begin
               cur_seen[i] = 1'b1;
            end
            if (prev_keys_ff[i] == cur_keys[j]) begin
               prev_seen[i] = 1'b1;
            end
         end
         press_mask[i]   = (cur_keys[i] != '0) && !cur_seen[i];
         release_mask[i] = (prev_keys_ff[i] != '0) && !prev_seen[i];
      end
   end

   // Reports without changes only update the stored report.
   assign q_push = accept && ((press_mask != '0) || (release_mask != '0));

   always_comb begin
      q_entry.mods         = req_ch.modifiers;
      q_entry.prev_mods    = prev_mods_ff;
      q_entry.cur_keys     = cur_keys;
      q_entry.prev_keys    = prev_keys_ff;
      q_entry.release_mask = release_mask;
      q_entry.press_mask   = press_mask;
   end

   always_comb begin
      prev_mods_in = prev_mods_ff;
      prev_keys_in = prev_keys_ff;
      if (accept) begin
         prev_mods_in = req_ch.modifiers;
         prev_keys_in = cur_keys;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mods_ff <= '0;
         prev_keys_ff <= '0;
      end else begin
         prev_mods_ff <= prev_mods_in;
         prev_keys_ff <= prev_keys_in;
      end
   end

endmodule

// File: hw/rtl/hrkcd_queue.sv
// Short queue of classified reports between front end and event sequencer.
// Depends on hrkcd_pkg.
module hrkcd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hrkcd_pkg::entry_type  push_entry,
   input  logic                  pop,
   output hrkcd_pkg::entry_type  head_entry,
   output hrkcd_pkg::qstat_type  qstat
);
   import hrkcd_pkg::*;

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign head_entry  = slots_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/hrkcd_back.sv
// Event sequencer: walks the head report's masks, one key event per cycle while the event register is free.
// Depends on hrkcd_pkg and hrkcd_rsp_if.
module hrkcd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hrkcd_pkg::entry_type  head_entry,
   input  hrkcd_pkg::qstat_type  qstat,
   output logic                  q_pop,
   hrkcd_rsp_if.source           rsp_ch
);
   import hrkcd_pkg::*;

   logic [EVENTS-1:0]               sent_ff;
   logic [EVENTS-1:0]               sent_in;
   logic [EVENTS-1:0]               pending;
   logic [EVENTS-1:0]               pick;
   logic [EVENT_IDX_W-1:0]          pick_idx;
   logic [EVENTS-1:0][KEY_W-1:0]    all_keys;
   logic                            pick_last;
   logic                            emit;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [KEY_W-1:0]                key_code_ff;
   logic [KEY_W-1:0]                event_mods_ff;
   logic                            pressed_ff;
   logic                            last_ff;

   // Presses occupy the low half so they come out first.
   assign pending  = {head_entry.release_mask, head_entry.press_mask} & ~sent_ff;
   assign pick     = pending & (~pending + 1'b1);
   assign pick_last = ((pending & (pending - 1'b1)) == '0);
   assign all_keys = {head_entry.prev_keys, head_entry.cur_keys};

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < EVENTS; i++) begin
         if (pick[i]) begin
            pick_idx = pick_idx | EVENT_IDX_W'(i);
         end
      end
   end

   assign emit  = !qstat.empty && (!rsp_valid_ff || rsp_ch.ready);
   assign q_pop = emit && pick_last;

   always_comb begin
      sent_in      = sent_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         // Clear the record once the report is done, else mark this event.
         sent_in = pick_last ? '0 : (sent_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         key_code_ff   <= all_keys[pick_idx];
         pressed_ff    <= (pick_idx < EVENT_IDX_W'(KEY_SLOTS));
         event_mods_ff <= (pick_idx < EVENT_IDX_W'(KEY_SLOTS)) ? head_entry.mods
                                                               : head_entry.prev_mods;
         last_ff       <= pick_last;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.key_code        = key_code_ff;
   assign rsp_ch.event_modifiers = event_mods_ff;
   assign rsp_ch.pressed         = pressed_ff;
   assign rsp_ch.last            = last_ff;

endmodule

// File: hw/rtl/hid_report_key_change_detect_core.sv
// Channel  Dir  Carries
// req_ch   in   one report: modifiers, key_1 .. key_6
// rsp_ch   out  one key event: key_code, event_modifiers, pressed, last
//
// The front end takes one report per cycle while the two-entry queue has room.
// The sequencer gives one event per cycle while its event register is free or
// being taken; a queued report carries 1 to 12 events and is popped with its last.
// Reset clears the stored report and the queue state; no clearing pass.
// A stalled event register stops the sequencer; the queue then fills and
// req_ch.ready drops.
module hid_report_key_change_detect_core (
   input  logic         clock,
   input  logic         reset,
   hrkcd_req_if.sink    req_ch,
   hrkcd_rsp_if.source  rsp_ch
);
   import hrkcd_pkg::*;

   `include "hid_report_key_change_detect_core_assert.svh"

   entry_type push_entry;
   entry_type head_entry;
   qstat_type qstat;
   logic      q_push;
   logic      q_pop;

   hrkcd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .qstat   (qstat),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   hrkcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   hrkcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .qstat      (qstat),
      .q_pop      (q_pop),
      .rsp_ch     (rsp_ch)
   );

   `HRKCD_ASSERT_NOW(a_no_push_full, q_push, !qstat.full)
   `HRKCD_ASSERT_NOW(a_no_pop_empty, q_pop, !qstat.empty)
   `HRKCD_ASSERT_NOW(a_full_blocks_req, qstat.full, !req_ch.ready)
   `HRKCD_ASSERT_NEXT(a_pop_gives_last, q_pop, rsp_ch.valid && rsp_ch.last)

endmodule

// File: verif/hid_report_key_change_detect_core_tb.sv
// Self-checking testbench for hid_report_key_change_detect_core.
// Depends on hrkcd_pkg and the hrkcd_req_if / hrkcd_rsp_if channel interfaces.
// Predicts press/release key words per report and checks them in order.
module hid_report_key_change_detect_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hrkcd_pkg::*;

   localparam int   RANDOM_REPORTS = 300;
   localparam int   MAX_GAP        = 5;
   localparam int   LONG_HOLD      = 60;
   localparam int   STALL_LIMIT    = 2000;
   localparam int   DRAIN_CYCLES   = 40;
   localparam int   PRINT_LIMIT    = 50;
   localparam logic KEY_DOWN       = 1'b1;
   localparam logic KEY_UP         = 1'b0;

   typedef struct packed {
      logic [KEY_W-1:0] mods;
      keys_type         keys;
   } kbd_report_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic [KEY_W-1:0] mods;
      logic             pressed;
      logic             last;
   } key_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrkcd_req_if req_ch ();
   hrkcd_rsp_if rsp_ch ();

   hid_report_key_change_detect_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kbd_report_type   reports_to_send[$];
   key_event_type    events_due[$];
   logic [KEY_W-1:0] prior_mods;
   keys_type         prior_keys;
   int               error_count   = 0;
   int               reports_taken = 0;
   int               idle_cycles   = 0;
   logic             req_taken     = 1'b0;
   logic             rsp_taken     = 1'b0;
   bit               send_burst    = 1'b0;
   bit               recv_burst    = 1'b0;
   int               send_gap      = 0;
   int               recv_wait     = 0;
   int               hold_left     = 0;
   int               next_hold_at  = 60;

   task automatic flag_error(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic bit holds_key(input keys_type set, input logic [KEY_W-1:0] code);
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (set[j] == code) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Presses of new keys in slot order, then releases of vanished keys, then store.
   task automatic diff_reports(input kbd_report_type r);
      key_event_type batch[EVENTS];
      int            n;
      n = 0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (r.keys[i] != '0 && !holds_key(prior_keys, r.keys[i])) begin
            batch[n] = '{key_code: r.keys[i], mods: r.mods, pressed: KEY_DOWN, last: 1'b0};
            n++;
         end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (prior_keys[i] != '0 && !holds_key(r.keys, prior_keys[i])) begin
            batch[n] = '{key_code: prior_keys[i], mods: prior_mods, pressed: KEY_UP,
                         last: 1'b0};
            n++;
         end
      end
      if (n > 0) batch[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) events_due.push_back(batch[k]);
      prior_mods = r.mods;
      prior_keys = r.keys;
   endtask

   function automatic kbd_report_type mk_report(input logic [7:0] m, input logic [7:0] a,
                                                input logic [7:0] b, input logic [7:0] c,
                                                input logic [7:0] d, input logic [7:0] e,
                                                input logic [7:0] f);
      kbd_report_type r;
      r.mods    = m;
      r.keys[0] = a;
      r.keys[1] = b;
      r.keys[2] = c;
      r.keys[3] = d;
      r.keys[4] = e;
      r.keys[5] = f;
      return r;
   endfunction

   task automatic add_directed_reports();
      reports_to_send.push_back(mk_report(8'h00, 0, 0, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'hFF, 0, 0, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h02, 8'h04, 0, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h00, 8'h04, 0, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h55, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      // same keys in other slots: nothing changes
      reports_to_send.push_back(mk_report(8'h55, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04));
      reports_to_send.push_back(mk_report(8'hAA, 0, 0, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h01, 8'h1E, 0, 8'h1E, 0, 0, 8'hFF));
      reports_to_send.push_back(mk_report(8'h80, 8'h01, 8'h1E, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h7F, 8'h2C, 8'h2C, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h00, 0, 0, 0, 0, 0, 0));
      reports_to_send.push_back(mk_report(8'h11, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
      // full turnover: six presses and six releases
      reports_to_send.push_back(mk_report(8'h22, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25));
      reports_to_send.push_back(mk_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      reports_to_send.push_back(mk_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
      reports_to_send.push_back(mk_report(8'h80, 8'h80, 8'h7F, 0, 8'h40, 0, 8'h01));
      reports_to_send.push_back(mk_report(8'h80, 8'h80, 8'h7F, 0, 8'h40, 0, 8'h01));
      reports_to_send.push_back(mk_report(8'h3C, 0, 0, 0, 0, 0, 8'h80));
      reports_to_send.push_back(mk_report(8'h00, 0, 0, 0, 0, 0, 0));
   endtask

   // Mostly plausible typing: one or two slots edited at a time, with noise mixed in.
   task automatic add_random_reports(input int count);
      keys_type    held;
      logic [7:0]  mods;
      int          pick;
      int          s;
      int          d;
      held = '0;
      mods = '0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            for (int e = 0; e < $urandom_range(1, 2); e++) begin
               s = $urandom_range(0, KEY_SLOTS - 1);
               if ($urandom_range(0, 1) == 0) held[s] = '0;
               else if ($urandom_range(0, 7) == 0) held[s] = 8'($urandom_range(1, 255));
               else held[s] = 8'($urandom_range(8'h04, 8'h65));
            end
            if ($urandom_range(0, 3) == 0) mods = 8'($urandom_range(0, 255));
         end else if (pick < 70) begin
            if ($urandom_range(0, 1) == 0) mods = 8'($urandom_range(0, 255));
         end else if (pick < 80) begin
            s = $urandom_range(0, KEY_SLOTS - 1);
            d = $urandom_range(0, KEY_SLOTS - 1);
            held[d] = held[s];
            if (held[d] == '0) held[d] = 8'($urandom_range(1, 255));
         end else if (pick < 95) begin
            mods = 8'($urandom_range(0, 255));
            for (int i = 0; i < KEY_SLOTS; i++) begin
               held[i] = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom_range(0, 255));
            end
         end else begin
            held = '0;
         end
         reports_to_send.push_back('{mods: mods, keys: held});
      end
   endtask

   // Driver: hold a word until taken, then wait out the drawn gap.
   always @(negedge clock) begin
      kbd_report_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
      end else if (send_gap > 0) begin
         req_ch.valid <= 1'b0;
         send_gap     <= send_gap - 1;
      end else if (reports_to_send.size() > 0) begin
         r = reports_to_send.pop_front();
         req_ch.modifiers <= r.mods;
         req_ch.key_1     <= r.keys[0];
         req_ch.key_2     <= r.keys[1];
         req_ch.key_3     <= r.keys[2];
         req_ch.key_4     <= r.keys[3];
         req_ch.key_5     <= r.keys[4];
         req_ch.key_6     <= r.keys[5];
         req_ch.valid     <= 1'b1;
         send_gap         <= draw_gap(send_burst);
         if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Receiver: random wait per word, plus a long hold-off now and then to back up the queue.
   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (reports_taken >= next_hold_at) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         next_hold_at <= next_hold_at + 150;
      end else if (rsp_taken) begin
         w = draw_gap(recv_burst);
         rsp_ch.ready <= (w == 0);
         recv_wait    <= (w == 0) ? 0 : w - 1;
         if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
      end else if (recv_wait > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_wait    <= recv_wait - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: predict on accepted reports, check accepted key words against the oldest due.
   always @(posedge clock) begin
      key_event_type got;
      key_event_type want;
      logic          req_fire;
      logic          rsp_fire;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      rsp_fire = !reset && rsp_ch.valid && rsp_ch.ready;
      req_taken <= req_fire;
      rsp_taken <= rsp_fire;
      if (reset) begin
         prior_mods = '0;
         prior_keys = '0;
      end
      if (req_fire) begin
         diff_reports('{mods: req_ch.modifiers,
                        keys: {req_ch.key_6, req_ch.key_5, req_ch.key_4,
                               req_ch.key_3, req_ch.key_2, req_ch.key_1}});
         reports_taken <= reports_taken + 1;
      end
      if (rsp_fire) begin
         got = '{key_code: rsp_ch.key_code, mods: rsp_ch.event_modifiers,
                 pressed: rsp_ch.pressed, last: rsp_ch.last};
         if (events_due.size() == 0) begin
            flag_error($sformatf("unexpected key word code %02h", got.key_code));
         end else begin
            want = events_due.pop_front();
            if (got.key_code !== want.key_code)
               flag_error($sformatf("key_code %02h, want %02h", got.key_code, want.key_code));
            if (got.mods !== want.mods)
               flag_error($sformatf("event_modifiers %02h, want %02h (code %02h)",
                                    got.mods, want.mods, want.key_code));
            if (got.pressed !== want.pressed)
               flag_error($sformatf("pressed %b, want %b (code %02h)",
                                    got.pressed, want.pressed, want.key_code));
            if (got.last !== want.last)
               flag_error($sformatf("last %b, want %b (code %02h)",
                                    got.last, want.last, want.key_code));
         end
      end
      if (!reset && !req_fire && !rsp_fire &&
          (reports_to_send.size() > 0 || events_due.size() > 0 || req_ch.valid)) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         idle_cycles <= 0;
      end
   end

   // Watchdog: end the run when the channels stay quiet with work outstanding.
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.modifiers = '0;
      req_ch.key_1     = '0;
      req_ch.key_2     = '0;
      req_ch.key_3     = '0;
      req_ch.key_4     = '0;
      req_ch.key_5     = '0;
      req_ch.key_6     = '0;
      rsp_ch.ready     = 1'b0;
      add_directed_reports();
      add_random_reports(RANDOM_REPORTS);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (reports_to_send.size() != 0 || req_ch.valid) @(negedge clock);
      while (events_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/hrkcd_pkg.sv
hw/rtl/hrkcd_if.sv
hw/rtl/hrkcd_front.sv
hw/rtl/hrkcd_queue.sv
hw/rtl/hrkcd_back.sv
hw/rtl/hid_report_key_change_detect_core.sv
verif/hid_report_key_change_detect_core_tb.sv
